FILE: sv/asbu_pkg.sv
// Shared types and fixed constants of the additive sprite blitter.
package asbu_pkg;

  // Command codes carried by the command field
  localparam logic [1:0] CMD_FADE = 2'd0;
  localparam logic [1:0] CMD_DRAW = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  // Fixed field widths
  localparam int CMD_W  = 2;
  localparam int POS_W  = 10;
  localparam int LIFE_W = 8;
  localparam int PIX_W  = 8;
  localparam int BLUE_W = 7;

  // Life value at which the brightness level reaches its top
  localparam int LIFE_OFFSET = 100;

  // v / 3 for 8-bit v as a reciprocal multiply: (v * 342) >> 10
  localparam int DIV3_W     = 17;
  localparam int DIV3_MUL   = 342;
  localparam int DIV3_SHIFT = 10;

  // One pixel step from the walker into the memory pipeline
  typedef struct packed {
    logic       valid;      // step present
    logic       clear;      // reset clearing pass, write zero
    logic [1:0] cmd;        // command of the transaction
    logic       in_bounds;  // pixel lies inside the frame
    logic       last;       // final step of the transaction
  } step_t;

endpackage

FILE: sv/additive_sprite_blitter_unit.sv
// Additive sprite blitter top: frame store pipeline, palette and result register.
//
//   channel   handshake           payload
//   input     in_valid/in_stall   command, pos_x, pos_y, life_left
//   output    out_valid/out_stall red, green, blue, in_frame
//
// One transaction at a time; the walker issues one pixel per cycle into a
// read-modify-write pipe around the single-port-read frame memory.
// Draw walks SPRITE_SIDE*SPRITE_SIDE pixels, fade FRAME_WIDTH*FRAME_HEIGHT,
// read or unused command a single step, with one memory access per pixel.
// After reset a clearing pass zeroes the store with in_stall high. A pending
// result waits in the output register while the next transaction is accepted.
module additive_sprite_blitter_unit #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 200,
  parameter int SPRITE_SIDE  = 16,
  parameter int LEVEL_COUNT  = 150
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [asbu_pkg::CMD_W-1:0]        command,
  input  logic signed [asbu_pkg::POS_W-1:0] pos_x,
  input  logic signed [asbu_pkg::POS_W-1:0] pos_y,
  input  logic [asbu_pkg::LIFE_W-1:0]       life_left,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [asbu_pkg::PIX_W-1:0]        red,
  output logic [asbu_pkg::PIX_W-1:0]        green,
  output logic [asbu_pkg::BLUE_W-1:0]       blue,
  output logic                              in_frame
);

  localparam int PIX_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW = $clog2(PIX_COUNT);
  localparam int KW = $clog2(SPRITE_SIDE * SPRITE_SIDE);

  // Exact floor(p / LEVEL_COUNT) for 16-bit p: multiply by ceil(2^SHIFT / L)
  localparam int PROD_W = 16;
  localparam int SHIFT  = PROD_W + $clog2(LEVEL_COUNT);
  localparam int RECIP_W = PROD_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(LEVEL_COUNT) - 64'd1) / 64'(LEVEL_COUNT));
  localparam int QW = PROD_W + RECIP_W;

  logic                    accept;
  logic                    walker_busy;
  asbu_pkg::step_t         step0;
  logic [AW-1:0]           addr0;
  logic [KW-1:0]           shape_idx;
  logic [7:0]              base;
  logic [7:0]              scale;
  logic [7:0]              scale_next;
  logic [7:0]              life_off;
  logic [PROD_W-1:0]       prod0;

  asbu_pkg::step_t         s1;
  logic [AW-1:0]           s1_addr;
  logic [PROD_W-1:0]       s1_prod;
  logic [QW-1:0]           q_full;
  logic                    rd_en;

  asbu_pkg::step_t         s2;
  logic [AW-1:0]           s2_addr;
  logic [7:0]              s2_add;
  logic [7:0]              rd_data;
  logic                    wr_en;
  logic [7:0]              wr_data;
  logic [8:0]              sum;
  logic [7:0]              v;
  logic [9:0]              v3;
  logic [asbu_pkg::DIV3_W-1:0] v_div3;

  logic                    res_pend;
  logic                    load_out;
  logic [7:0]              res_red;
  logic [7:0]              res_green;
  logic [6:0]              res_blue;
  logic                    res_in_frame;
  logic                    s2_done;

  assign accept   = in_valid && !in_stall;
  assign in_stall = walker_busy || s1.valid || s2.valid || res_pend;

  // Scale factor: LEVEL_COUNT - level, i.e. life - 100 clamped to 1..LEVEL_COUNT
  always_comb begin
    life_off = life_left - 8'(asbu_pkg::LIFE_OFFSET);
    if (life_left <= 8'(asbu_pkg::LIFE_OFFSET)) begin
      scale_next = 8'd1;
    end else if (life_off >= 8'(LEVEL_COUNT)) begin
      scale_next = 8'(LEVEL_COUNT);
    end else begin
      scale_next = life_off;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scale <= scale_next;
    end
  end

  asbu_walker #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .SPRITE_SIDE  (SPRITE_SIDE)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .cmd       (command),
    .px        (pos_x),
    .py        (pos_y),
    .step      (step0),
    .addr      (addr0),
    .shape_idx (shape_idx),
    .busy      (walker_busy)
  );

  asbu_shape_rom #(
    .SPRITE_SIDE (SPRITE_SIDE)
  ) u_shape_rom (
    .idx  (shape_idx),
    .base (base)
  );

  // Stage 0: weight the sprite base by the scale
  assign prod0 = PROD_W'(base) * PROD_W'(scale);

  // Stage 1: issue the memory read, divide the weighted base by LEVEL_COUNT
  assign rd_en  = s1.valid && s1.in_bounds && !s1.clear;
  assign q_full = QW'(s1_prod) * QW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      s1 <= step0;
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= addr0;
    s1_prod <= prod0;
    s2_addr <= s1_addr;
    s2_add  <= q_full[SHIFT +: 8];
  end

  asbu_frame_mem #(
    .DEPTH (PIX_COUNT)
  ) u_frame_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (s1_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s2_addr),
    .wr_data (wr_data)
  );

  // Stage 2: modify and write back
  always_comb begin
    sum     = {1'b0, rd_data} + {1'b0, s2_add};
    wr_en   = 1'b0;
    wr_data = 8'd0;
    if (s2.valid) begin
      if (s2.clear) begin
        wr_en   = 1'b1;
        wr_data = 8'd0;
      end else if (s2.cmd == asbu_pkg::CMD_FADE) begin
        wr_en   = 1'b1;
        wr_data = {1'b0, rd_data[7:1]};
      end else if ((s2.cmd == asbu_pkg::CMD_DRAW) && s2.in_bounds) begin
        wr_en   = 1'b1;
        wr_data = sum[8] ? 8'hFF : sum[7:0];
      end
    end
  end

  // Fire palette of the read pixel
  always_comb begin
    v      = (s2.in_bounds && (s2.cmd == asbu_pkg::CMD_READ)) ? rd_data : 8'd0;
    v3     = {2'b00, v} + {1'b0, v, 1'b0};
    v_div3 = asbu_pkg::DIV3_W'(v) * asbu_pkg::DIV3_W'(asbu_pkg::DIV3_MUL);
  end

  assign s2_done  = s2.valid && s2.last && !s2.clear;
  assign load_out = res_pend && (!out_valid || !out_stall);

  // Hold the finished result until the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      res_pend <= 1'b0;
    end else if (s2_done) begin
      res_pend <= 1'b1;
    end else if (load_out) begin
      res_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_done) begin
      res_red      <= v;
      res_green    <= v3[9:2];
      res_blue     <= v_div3[asbu_pkg::DIV3_SHIFT +: asbu_pkg::BLUE_W];
      res_in_frame <= s2.in_bounds && (s2.cmd == asbu_pkg::CMD_READ);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      red      <= res_red;
      green    <= res_green;
      blue     <= res_blue;
      in_frame <= res_in_frame;
    end
  end

endmodule

FILE: sv/asbu_frame_mem.sv
// Intensity frame store: one write port, one registered read port.
module asbu_frame_mem #(
  parameter int DEPTH = 64000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered and presented in the cycle after the address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/asbu_shape_rom.sv
// Radial sprite base shape, built as a constant table at elaboration.
module asbu_shape_rom #(
  parameter int SPRITE_SIDE = 16,
  localparam int KW = $clog2(SPRITE_SIDE * SPRITE_SIDE)
) (
  input  logic [KW-1:0] idx,
  output logic [7:0]    base
);

  // floor(255 * (1 - 2d/side)) clamped at 0, exact in integers:
  // find the smallest m with (m*side)^2 >= 260100 * d^2, value 255 - m
  function automatic logic [7:0] shape_val(input int x, input int y);
    longint half;
    longint dx;
    longint dy;
    longint target;
    longint lo;
    longint hi;
    longint mid;
    longint t;
    half   = longint'(SPRITE_SIDE >> 1);
    dx     = longint'(x) - half;
    dy     = longint'(y) - half;
    target = 64'd260100 * (dx * dx + dy * dy);
    lo     = 0;
    hi     = 64'd1 << 20;
    for (int i = 0; i < 22; i++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        t   = mid * longint'(SPRITE_SIDE);
        if (t * t >= target) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
    end
    if (lo >= 255) begin
      return 8'd0;
    end
    return 8'(255 - lo);
  endfunction

  logic [7:0] shape_tab [SPRITE_SIDE * SPRITE_SIDE];

  // Fill the table one entry per sprite pixel
  for (genvar gy = 0; gy < SPRITE_SIDE; gy++) begin : g_row
    for (genvar gx = 0; gx < SPRITE_SIDE; gx++) begin : g_col
      localparam logic [7:0] ENTRY = shape_val(gx, gy);
      assign shape_tab[gy * SPRITE_SIDE + gx] = ENTRY;
    end
  end

  assign base = shape_tab[idx];

endmodule

FILE: sv/asbu_walker.sv
// Step sequencer: clearing pass, fade sweep, sprite scan and single read or unused command steps.
module asbu_walker #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 200,
  parameter int SPRITE_SIDE  = 16,
  localparam int PIX_COUNT = FRAME_WIDTH * FRAME_HEIGHT,
  localparam int AW = $clog2(PIX_COUNT),
  localparam int KW = $clog2(SPRITE_SIDE * SPRITE_SIDE)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [asbu_pkg::CMD_W-1:0] cmd,
  input  logic [asbu_pkg::POS_W-1:0] px,
  input  logic [asbu_pkg::POS_W-1:0] py,
  output asbu_pkg::step_t            step,
  output logic [AW-1:0]              addr,
  output logic [KW-1:0]              shape_idx,
  output logic                       busy
);

  // Coordinates: position plus sprite offset, two guard bits for sign and range
  localparam int CW = asbu_pkg::POS_W + 2;
  localparam int SW = $clog2(SPRITE_SIDE);
  localparam int XW = $clog2(FRAME_WIDTH);
  localparam int YW = $clog2(FRAME_HEIGHT);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_FADE  = 3'd2;
  localparam logic [2:0] ST_DRAW  = 3'd3;
  localparam logic [2:0] ST_ONE   = 3'd4;

  logic [2:0]                 state;
  logic [AW-1:0]              sweep;
  logic [SW-1:0]              sx;
  logic [SW-1:0]              sy;
  logic [KW-1:0]              k;
  logic [asbu_pkg::CMD_W-1:0] cmd_q;
  logic [asbu_pkg::POS_W-1:0] px_q;
  logic [asbu_pkg::POS_W-1:0] py_q;

  logic [CW-1:0] cx;
  logic [CW-1:0] cy;
  logic          pos_inside;
  logic [AW-1:0] pix_addr;
  logic          sweep_last;
  logic          scan_last;

  // Pixel position of the current sprite step and its frame address
  always_comb begin
    cx = {{(CW - asbu_pkg::POS_W){px_q[asbu_pkg::POS_W-1]}}, px_q} + CW'(sx);
    cy = {{(CW - asbu_pkg::POS_W){py_q[asbu_pkg::POS_W-1]}}, py_q} + CW'(sy);
    pos_inside = !cx[CW-1] && (cx < CW'(FRAME_WIDTH)) &&
                 !cy[CW-1] && (cy < CW'(FRAME_HEIGHT));
    pix_addr = AW'(cy[YW-1:0]) * AW'(FRAME_WIDTH) + AW'(cx[XW-1:0]);
  end

  assign sweep_last = (sweep == AW'(PIX_COUNT - 1));
  assign scan_last  = (sx == SW'(SPRITE_SIDE - 1)) && (sy == SW'(SPRITE_SIDE - 1));

  // Present one step per cycle from the active state
  always_comb begin
    step      = '0;
    addr      = pix_addr;
    shape_idx = k;
    case (state)
      ST_CLEAR: begin
        step.valid     = 1'b1;
        step.clear     = 1'b1;
        step.cmd       = asbu_pkg::CMD_FADE;
        step.in_bounds = 1'b1;
        step.last      = sweep_last;
        addr           = sweep;
      end
      ST_FADE: begin
        step.valid     = 1'b1;
        step.cmd       = asbu_pkg::CMD_FADE;
        step.in_bounds = 1'b1;
        step.last      = sweep_last;
        addr           = sweep;
      end
      ST_DRAW: begin
        step.valid     = 1'b1;
        step.cmd       = asbu_pkg::CMD_DRAW;
        step.in_bounds = pos_inside;
        step.last      = scan_last;
      end
      ST_ONE: begin
        step.valid     = 1'b1;
        step.cmd       = cmd_q;
        step.in_bounds = pos_inside && (cmd_q == asbu_pkg::CMD_READ);
        step.last      = 1'b1;
      end
      default: begin
        step = '0;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      sweep <= '0;
      sx    <= '0;
      sy    <= '0;
      k     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            sweep <= '0;
            sx    <= '0;
            sy    <= '0;
            k     <= '0;
            if (cmd == asbu_pkg::CMD_FADE) begin
              state <= ST_FADE;
            end else if (cmd == asbu_pkg::CMD_DRAW) begin
              state <= ST_DRAW;
            end else begin
              state <= ST_ONE;
            end
          end
        end
        ST_CLEAR, ST_FADE: begin
          sweep <= sweep + AW'(1);
          if (sweep_last) begin
            state <= ST_IDLE;
          end
        end
        ST_DRAW: begin
          k <= k + KW'(1);
          if (sx == SW'(SPRITE_SIDE - 1)) begin
            sx <= '0;
            sy <= sy + SW'(1);
          end else begin
            sx <= sx + SW'(1);
          end
          if (scan_last) begin
            state <= ST_IDLE;
          end
        end
        ST_ONE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the transaction fields
  always_ff @(posedge clk) begin
    if (start && (state == ST_IDLE)) begin
      cmd_q <= cmd;
      px_q  <= px;
      py_q  <= py;
    end
  end

endmodule

FILE: sv/asbu_checker.sv
// Port-level checks of the additive sprite blitter, bound to the top level.
module asbu_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [asbu_pkg::PIX_W-1:0]        red,
  input logic [asbu_pkg::PIX_W-1:0]        green,
  input logic [asbu_pkg::BLUE_W-1:0]       blue,
  input logic                              in_frame
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red) && $stable(green) &&
      $stable(blue) && $stable(in_frame))
    else $error("stalled result changed");

  // Clearing pass keeps the input closed right after reset
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("input open during clearing pass");

  // An accepted transaction closes the input for at least the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted back to back");

  // Results without in_frame (outside an in-bounds read) are all zero
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_frame |-> red == 8'd0 && green == 8'd0 && blue == 7'd0)
    else $error("nonzero result without in_frame");

  // Palette relations of green and blue to red
  a_palette: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> green == 8'((10'(red) * 10'd3) >> 2) &&
      (9'(blue) * 9'd3 <= 9'(red)) && (9'(red) < 9'(blue) * 9'd3 + 9'd3))
    else $error("palette mismatch");

endmodule

bind additive_sprite_blitter_unit asbu_checker u_asbu_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for the additive sprite blitter unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asbu_pkg::*;

  localparam int FRAME_W   = 320;
  localparam int FRAME_H   = 200;
  localparam int SPRITE_N  = 16;
  localparam int LEVELS    = 150;
  localparam int FRAME_PIX = FRAME_W * FRAME_H;
  localparam int SHAPE_PIX = SPRITE_N * SPRITE_N;

  // Cycles with no transaction on either side before the run is abandoned;
  // a fade or the clearing pass alone takes a whole frame walk.
  localparam int STALL_LIMIT = 4 * (FRAME_PIX + 4);
  localparam int HOLD_CYCLES = 2500;
  localparam int RAND_ITEMS  = 412;
  localparam int CALM_FROM   = 360;

  typedef struct packed {
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [BLUE_W-1:0] blue;
    logic              in_frame;
  } palette_px_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [LIFE_W-1:0]       life;
    logic                    typed;
    palette_px_t             want;
  } stim_row_t;

  localparam palette_px_t PX_NONE = '0;
  localparam palette_px_t PX_DARK = '{8'd0, 8'd0, 7'd0, 1'b1};
  localparam palette_px_t PX_FULL = '{8'd255, 8'd191, 7'd85, 1'b1};

  // Directed transactions; typed rows carry their own expected result
  localparam int DIR_ROWS = 26;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{CMD_READ,    10'sd0,    10'sd0,   8'd0,   1'b1, PX_DARK},
    '{CMD_READ,  10'sd319,  10'sd199,   8'd0,   1'b1, PX_DARK},
    '{CMD_READ,   -10'sd1,    10'sd0,   8'd0,   1'b1, PX_NONE},
    '{CMD_READ,  10'sd320,    10'sd5,   8'd0,   1'b1, PX_NONE},
    '{CMD_READ,    10'sd5,  10'sd200,   8'd0,   1'b1, PX_NONE},
    '{CMD_READ, -10'sd512, -10'sd512,   8'd0,   1'b1, PX_NONE},
    '{CMD_READ,  10'sd511,  10'sd511, 8'd255,   1'b1, PX_NONE},
    '{CMD_NOP,     10'sd0,    10'sd0,   8'd0,   1'b1, PX_NONE},
    '{CMD_NOP,   10'sd511,   -10'sd1, 8'd255,   1'b1, PX_NONE},
    '{CMD_FADE,    10'sd0,    10'sd0,   8'd0,   1'b1, PX_NONE},
    '{CMD_DRAW,  10'sd100,   10'sd50, 8'd255,   1'b1, PX_NONE},
    '{CMD_READ,  10'sd108,   10'sd58,   8'd0,   1'b1, PX_FULL},
    '{CMD_DRAW,  10'sd100,   10'sd50, 8'd255,   1'b1, PX_NONE},
    '{CMD_READ,  10'sd108,   10'sd58,   8'd0,   1'b1, PX_FULL},
    '{CMD_READ,  10'sd101,   10'sd51,   8'd0,   1'b0, PX_NONE},
    '{CMD_DRAW,   -10'sd8,   -10'sd8,   8'd0,   1'b1, PX_NONE},
    '{CMD_READ,    10'sd0,    10'sd0,   8'd0,   1'b0, PX_NONE},
    '{CMD_DRAW,  10'sd312,  10'sd192, 8'd101,   1'b1, PX_NONE},
    '{CMD_READ,  10'sd319,  10'sd199,   8'd0,   1'b0, PX_NONE},
    '{CMD_DRAW,  10'sd304,  10'sd184, 8'd250,   1'b1, PX_NONE},
    '{CMD_READ,  10'sd312,  10'sd192,   8'd0,   1'b0, PX_NONE},
    '{CMD_DRAW, -10'sd512,  10'sd511, 8'd128,   1'b1, PX_NONE},
    '{CMD_DRAW,  10'sd511, -10'sd512, 8'd200,   1'b1, PX_NONE},
    '{CMD_FADE,    10'sd0,    10'sd0,   8'd0,   1'b1, PX_NONE},
    '{CMD_READ,  10'sd108,   10'sd58,   8'd0,   1'b0, PX_NONE},
    '{CMD_READ,  10'sd312,  10'sd192,   8'd0,   1'b0, PX_NONE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] command = CMD_NOP;
  logic signed [POS_W-1:0] pos_x = '0;
  logic signed [POS_W-1:0] pos_y = '0;
  logic [LIFE_W-1:0] life_left = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [BLUE_W-1:0] blue;
  logic in_frame;

  // Side data that travels with the driven transaction
  logic tag_typed = 1'b0;
  palette_px_t tag_want = '0;

  bit [PIX_W-1:0] frame_model [FRAME_PIX];
  bit [PIX_W-1:0] sprite_rom [SHAPE_PIX];
  palette_px_t pixel_q [$];
  int err_cnt = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  additive_sprite_blitter_unit #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_HEIGHT(FRAME_H),
    .SPRITE_SIDE (SPRITE_N),
    .LEVEL_COUNT (LEVELS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .life_left(life_left),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .in_frame (in_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fill the radial gradient: 255 minus ceil(510 * dist / side), floored at zero
  function automatic void build_sprite_rom();
    int dx, dy, sx, sy;
    longint unsigned target, lo, hi, mid, t;
    for (sy = 0; sy < SPRITE_N; sy++) begin
      for (sx = 0; sx < SPRITE_N; sx++) begin
        dx = sx - SPRITE_N / 2;
        dy = sy - SPRITE_N / 2;
        target = 64'd260100 * longint'(dx * dx + dy * dy);
        lo = 0;
        hi = 64'd1 << 20;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          t = mid * SPRITE_N;
          if (t * t >= target) hi = mid;
          else lo = mid + 1;
        end
        sprite_rom[sy * SPRITE_N + sx] = (lo >= 255) ? 8'd0 : 8'(255 - lo);
      end
    end
  endfunction

  // Apply one transaction to the frame model and return its palette result
  function automatic palette_px_t blit_predict(input logic [CMD_W-1:0] cmd,
                                               input logic signed [POS_W-1:0] px,
                                               input logic signed [POS_W-1:0] py,
                                               input logic [LIFE_W-1:0] life);
    palette_px_t res;
    int level, scale, sx, sy, cx, cy, idx, sum, v;
    res = '0;
    case (cmd)
      CMD_FADE: begin
        for (idx = 0; idx < FRAME_PIX; idx++) frame_model[idx] = frame_model[idx] >> 1;
      end
      CMD_DRAW: begin
        level = LEVELS + LIFE_OFFSET - int'(life);
        if (level < 0) level = 0;
        if (level > LEVELS - 1) level = LEVELS - 1;
        scale = LEVELS - level;
        for (sy = 0; sy < SPRITE_N; sy++) begin
          for (sx = 0; sx < SPRITE_N; sx++) begin
            cx = int'(px) + sx;
            cy = int'(py) + sy;
            if (cx >= 0 && cx < FRAME_W && cy >= 0 && cy < FRAME_H) begin
              idx = cy * FRAME_W + cx;
              sum = int'(frame_model[idx]) +
                    int'(sprite_rom[sy * SPRITE_N + sx]) * scale / LEVELS;
              frame_model[idx] = (sum > 255) ? 8'd255 : 8'(sum);
            end
          end
        end
      end
      CMD_READ: begin
        cx = int'(px);
        cy = int'(py);
        if (cx >= 0 && cx < FRAME_W && cy >= 0 && cy < FRAME_H) begin
          v = int'(frame_model[cy * FRAME_W + cx]);
          res.red      = PIX_W'(v);
          res.green    = PIX_W'(v * 3 / 4);
          res.blue     = BLUE_W'(v / 3);
          res.in_frame = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Check delivered pixels, then record the prediction for an accepted transaction
  always @(posedge clk) begin : scoreboard
    palette_px_t got, want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{red, green, blue, in_frame};
        if (pixel_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result r=%0d g=%0d b=%0d f=%0b",
                   $time, got.red, got.green, got.blue, got.in_frame);
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            $display({"%0t: mismatch expected r=%0d g=%0d b=%0d f=%0b",
                      " actual r=%0d g=%0d b=%0d f=%0b"},
                     $time, want.red, want.green, want.blue, want.in_frame,
                     got.red, got.green, got.blue, got.in_frame);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = blit_predict(command, pos_x, pos_y, life_left);
        pixel_q.push_back(tag_typed ? tag_want : want);
      end
    end
  end

  // Abandon the run when neither side moves a transaction for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm
  initial begin : receiver
    int burst_left, hold_left;
    burst_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
        burst_left = 0;
      end else if (burst_left != 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if ($urandom_range(4, 0) == 0) begin
        burst_left = $urandom_range(7, 1) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic send_txn(input logic [CMD_W-1:0] cmd, input logic signed [POS_W-1:0] x,
                          input logic signed [POS_W-1:0] y, input logic [LIFE_W-1:0] life,
                          input logic typed, input palette_px_t want);
    @(negedge clk);
    in_valid  <= 1'b1;
    command   <= cmd;
    pos_x     <= x;
    pos_y     <= y;
    life_left <= life;
    tag_typed <= typed;
    tag_want  <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // At random, drop valid for a burst of cycles unless the run is in a calm stretch
  task automatic maybe_gap();
    int n;
    if (!calm && $urandom_range(4, 0) == 0) begin
      n = $urandom_range(7, 1);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  initial begin : driver
    int i, k, r, last_x, last_y;
    logic [CMD_W-1:0] c;
    logic signed [POS_W-1:0] x, y;
    build_sprite_rom();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (i = 0; i < DIR_ROWS; i++) begin
      send_txn(DIRECTED[i].cmd, DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].life,
               DIRECTED[i].typed, DIRECTED[i].want);
      maybe_gap();
    end

    // Random draws, reads, fades and no-ops, with reads aimed mostly at freshly drawn sprites
    last_x = 100;
    last_y = 50;
    for (i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= CALM_FROM) || ((i % 80) < 12);
      if (i == 150) begin
        // Hold the receiver off while reads keep arriving so the block backs up
        hold_req = 1'b1;
        for (k = 0; k < 12; k++)
          send_txn(CMD_READ, POS_W'(last_x + k), POS_W'(last_y + k), 8'(k), 1'b0, PX_NONE);
      end
      if (i == 250) begin
        // Pause the sender until every pending pixel has come back
        @(negedge clk);
        in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
      end
      r = $urandom_range(99, 0);
      if (i % 90 == 89) begin
        c = CMD_FADE;
      end else if (r < 40) begin
        c = CMD_DRAW;
      end else if (r < 95) begin
        c = CMD_READ;
      end else begin
        c = CMD_NOP;
      end
      r = $urandom_range(99, 0);
      if (c == CMD_DRAW) begin
        if (r < 85) begin
          x = POS_W'(int'($urandom_range(335, 0)) - 16);
          y = POS_W'(int'($urandom_range(231, 0)) - 16);
        end else begin
          x = POS_W'($urandom);
          y = POS_W'($urandom);
        end
        last_x = int'(x);
        last_y = int'(y);
      end else if (r < 60) begin
        x = POS_W'(last_x + int'($urandom_range(15, 0)));
        y = POS_W'(last_y + int'($urandom_range(15, 0)));
      end else if (r < 85) begin
        x = POS_W'(int'($urandom_range(323, 0)) - 2);
        y = POS_W'(int'($urandom_range(203, 0)) - 2);
      end else begin
        x = POS_W'($urandom);
        y = POS_W'($urandom);
      end
      send_txn(c, x, y, LIFE_W'($urandom), 1'b0, PX_NONE);
      maybe_gap();
    end

    // Drain, then allow a draw's worth of cycles for stray results
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SHAPE_PIX + 16) @(posedge clk);
    if (err_cnt == 0 && pixel_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
